// ----- rtl/delay_line_pitch_shifter_core_defines.svh -----
// Assertion macros used by the checker file of the pitch shifter.
`ifndef DELAY_LINE_PITCH_SHIFTER_CORE_DEFINES_SVH
`define DELAY_LINE_PITCH_SHIFTER_CORE_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define DLPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pitch shifter check failed");

// Next-cycle implication, held off while reset is high.
`define DLPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pitch shifter check failed");

`endif

// ----- rtl/dlps_pkg.sv -----
// Shared types and constants of the delay-line pitch shifter.
package dlps_pkg;

  localparam int SAMPLE_W = 24;
  localparam int RATIO_W  = 18;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [RATIO_W-1:0]         ratio_t;

  // Register map (index into the register list).
  localparam int REG_PITCH_RATIO = 0;
  localparam ratio_t RATIO_RESET = 18'd65536;

  // Output queue and request credits.
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = 2;
  localparam int CNT_W       = 3;

  // Source selection for one store read, aligned with its read data.
  typedef struct packed {
    logic valid;
    logic fwd;   // take the sample written in the same cycle
    logic zero;  // entry not yet written since reset
  } tap_ctl_t;

endpackage

// ----- rtl/dlps_store.sv -----
// Ring sample store: one write port, one registered read port.
module dlps_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  dlps_pkg::sample_t wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output dlps_pkg::sample_t rdata
);
  import dlps_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/dlps_interp.sv -----
// Linear interpolation pipeline between two store reads.
module dlps_interp #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dlps_pkg::tap_ctl_t       tap0,
  input  dlps_pkg::tap_ctl_t       tap1,
  input  dlps_pkg::sample_t        rdata,
  input  dlps_pkg::sample_t        fwd_sample,
  input  logic [FRACTION_BITS-1:0] frac,
  output logic                     res_valid,
  output dlps_pkg::sample_t        res
);
  import dlps_pkg::*;

  localparam int DW = SAMPLE_W + 1;
  localparam int PW = FRACTION_BITS + 1 + DW;

  sample_t                  s0_sel;
  sample_t                  s1_sel;
  sample_t                  s0_a;
  logic [FRACTION_BITS-1:0] frac_a;
  sample_t                  s0_b;
  logic signed [PW-1:0]     prod_b;
  logic                     v_b;
  logic signed [DW-1:0]     diff;
  logic signed [PW-1:0]     shifted;
  logic signed [PW-1:0]     sum;

  always_comb begin
    priority if (tap0.fwd) begin
      s0_sel = fwd_sample;
    end else if (tap0.zero) begin
      s0_sel = '0;
    end else begin
      s0_sel = rdata;
    end
    s1_sel = tap1.zero ? '0 : rdata;
    diff   = {s1_sel[SAMPLE_W-1], s1_sel} - {s0_a[SAMPLE_W-1], s0_a};
  end

  // Capture the first entry and the fraction.
  always_ff @(posedge clk) begin
    if (tap0.valid) begin
      s0_a   <= s0_sel;
      frac_a <= frac;
    end
  end

  // Multiply the fraction by the difference.
  always_ff @(posedge clk) begin
    if (tap1.valid) begin
      prod_b <= $signed({1'b0, frac_a}) * diff;
      s0_b   <= s0_a;
    end
  end

  // Arithmetic shift floors the product.
  assign shifted = prod_b >>> FRACTION_BITS;
  assign sum     = {{(PW-SAMPLE_W){s0_b[SAMPLE_W-1]}}, s0_b} + shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v_b       <= tap1.valid;
      res_valid <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (v_b) begin
      res <= sum[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- rtl/dlps_ofifo.sv -----
// Small output queue that decouples the pipeline from a stalled receiver.
module dlps_ofifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dlps_pkg::sample_t push_data,
  input  logic              out_ready,
  output logic              out_valid,
  output dlps_pkg::sample_t sample_out
);
  import dlps_pkg::*;

  sample_t              entries [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]  wr_ptr;
  logic [OFIFO_AW-1:0]  rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign sample_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OFIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OFIFO_AW'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/delay_line_pitch_shifter_core.sv -----
// Top level of the delay-line pitch shifter: sequencer, pointers, register port.
//
// Input channel in_valid/in_ready/sample_in takes one 24-bit signed sample per
// request; output channel out_valid/out_ready/sample_out returns one
// interpolated sample per input, in order.
// A new sample is not taken while the last one makes its second store read: the
// single read port of the sample store serves both interpolation taps, one in
// each cycle of an item. A result passes the second store read, the multiply
// stage, the add stage and the output queue write before it is shown.
// pitch_ratio sits at byte address 0 of the APB port (18 bits, unsigned,
// 16 fraction bits); write it only while the block is idle. pready is tied high.
// Reset clears pointers, read position, queue and credits, and sets the ratio
// to 1.0. The store itself is not swept: a fill mark (write pointer plus a
// wrapped flag) makes unwritten entries read as zero, so the block is ready
// in the first cycle after reset. DEPTH must be a power of two.
// A stalled receiver fills a four-entry output queue; in_ready drops once
// four results are queued or in flight, and nothing is lost.
module delay_line_pitch_shifter_core #(
  parameter int DEPTH         = 2048,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dlps_pkg::sample_t sample_in,
  output logic              out_valid,
  input  logic              out_ready,
  output dlps_pkg::sample_t sample_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dlps_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int POS_W  = AW + FRACTION_BITS;
  localparam int EXT_W  = (POS_W > RATIO_W) ? POS_W : RATIO_W;
  localparam logic [POS_W-1:0] HALF_POS    = POS_W'(DEPTH / 2) << FRACTION_BITS;
  localparam logic [POS_W-1:0] QUARTER_POS = POS_W'(DEPTH / 4) << FRACTION_BITS;
  localparam logic [AW-1:0]    HALF_IDX    = AW'(DEPTH / 2);
  localparam logic [AW-1:0]    QUARTER_IDX = AW'(DEPTH / 4);
  localparam logic [AW-1:0]    LAST_IDX    = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'b01,
    PH_SECOND = 2'b10
  } phase_t;

  phase_t                   phase;
  ratio_t                   pitch_ratio;
  logic [AW-1:0]            wp;
  logic                     wrapped;
  logic [POS_W-1:0]         pos;
  logic [AW-1:0]            idx0;
  logic [AW-1:0]            idx1_q;
  logic [FRACTION_BITS-1:0] frac_q;
  sample_t                  sample_q;
  logic [CNT_W-1:0]         used;
  logic                     acc_in;
  logic                     acc_out;
  logic                     cfg_wr;
  logic [EXT_W-1:0]         ratio_ext;
  logic [POS_W-1:0]         step;
  logic [POS_W-1:0]         wpos;
  logic [POS_W-1:0]         lag;
  logic [POS_W-1:0]         pos_resync;
  logic                     re;
  logic [AW-1:0]            raddr;
  sample_t                  rdata;
  tap_ctl_t                 tap0;
  tap_ctl_t                 tap1;
  logic                     res_valid;
  sample_t                  res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == 1'(REG_PITCH_RATIO)) ? 32'(pitch_ratio) : '0;

  assign in_ready = (phase == PH_FIRST) && (used < CNT_W'(OFIFO_DEPTH));
  assign acc_in   = in_valid && in_ready;
  assign acc_out  = out_valid && out_ready;

  assign idx0      = pos[POS_W-1:FRACTION_BITS];
  assign ratio_ext = EXT_W'(pitch_ratio);
  assign step      = ratio_ext[POS_W-1:0];

  // Keep the read position within a quarter to a half depth behind the writer.
  always_comb begin
    wpos = {wp, {FRACTION_BITS{1'b0}}};
    lag  = wpos - pos;
    priority if (lag > HALF_POS) begin
      pos_resync = {wp - QUARTER_IDX, {FRACTION_BITS{1'b0}}};
    end else if (lag < QUARTER_POS) begin
      pos_resync = {wp - HALF_IDX, {FRACTION_BITS{1'b0}}};
    end else begin
      pos_resync = pos;
    end
  end

  assign re    = acc_in || (phase == PH_SECOND);
  assign raddr = (phase == PH_SECOND) ? idx1_q : idx0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_ratio <= RATIO_RESET;
    end else if (cfg_wr && paddr[2] == 1'(REG_PITCH_RATIO)) begin
      pitch_ratio <= pwdata[RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_FIRST;
      wp      <= '0;
      wrapped <= 1'b0;
      pos     <= '0;
      used    <= '0;
      tap0    <= '0;
      tap1    <= '0;
    end else begin
      used <= used + CNT_W'(acc_in) - CNT_W'(acc_out);
      tap0 <= '0;
      tap1 <= '0;
      unique case (phase)
        PH_FIRST: begin
          if (acc_in) begin
            tap0.valid <= 1'b1;
            tap0.fwd   <= (idx0 == wp);
            tap0.zero  <= !(wrapped || idx0 < wp);
            wp         <= wp + AW'(1);
            if (wp == LAST_IDX) begin
              wrapped <= 1'b1;
            end
            pos   <= pos + step;
            phase <= PH_SECOND;
          end
        end
        PH_SECOND: begin
          // Store already holds this item's sample; only unwritten entries read zero.
          tap1.valid <= 1'b1;
          tap1.fwd   <= 1'b0;
          tap1.zero  <= !(wrapped || idx1_q < wp);
          pos        <= pos_resync;
          phase      <= PH_FIRST;
        end
        default: begin
          phase <= PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      idx1_q   <= idx0 + AW'(1);
      frac_q   <= pos[FRACTION_BITS-1:0];
      sample_q <= sample_in;
    end
  end

  dlps_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (acc_in),
    .waddr (wp),
    .wdata (sample_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  dlps_interp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .tap0       (tap0),
    .tap1       (tap1),
    .rdata      (rdata),
    .fwd_sample (sample_q),
    .frac       (frac_q),
    .res_valid  (res_valid),
    .res        (res)
  );

  dlps_ofifo u_ofifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .sample_out (sample_out)
  );

endmodule

// ----- rtl/dlps_checker.sv -----
// Port-level checks of the pitch shifter, bound to the top level.
`include "delay_line_pitch_shifter_core_defines.svh"

module dlps_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dlps_pkg::sample_t sample_out,
  input logic              pready
);

  // No request is taken right after another.
  `DLPS_ASSERT_NEXT(a_in_cadence, in_valid && in_ready, !in_ready)

  // A stalled result holds its value.
  `DLPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out))

  // Nothing is offered in the first cycle after reset.
  `DLPS_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

  // The register port never inserts wait states.
  `DLPS_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind delay_line_pitch_shifter_core dlps_checker u_dlps_checker (.*);

// ----- bench/delay_line_pitch_shifter_core_tb.sv -----
// Self-checking testbench for the delay-line pitch shifter core.
`timescale 1ns / 1ps

module delay_line_pitch_shifter_core_tb;
  import dlps_pkg::*;

  localparam int RING_DEPTH = 2048;
  localparam int FRAC_BITS  = 16;
  localparam int PTR_W      = 11;
  localparam int POS_W      = PTR_W + FRAC_BITS;
  localparam logic [POS_W-1:0] HALF_SPAN    = POS_W'(RING_DEPTH / 2) << FRAC_BITS;
  localparam logic [POS_W-1:0] QUARTER_SPAN = POS_W'(RING_DEPTH / 4) << FRAC_BITS;
  localparam logic [2:0] RATIO_ADDR  = 3'(4 * REG_PITCH_RATIO);
  localparam logic [2:0] UNUSED_ADDR = 3'd4;
  localparam int PHASE_ITEMS    = 135;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH, IDLE_PRESSURE} idle_mode_e;

  typedef struct packed {
    logic        set_ratio;
    logic [31:0] ratio_word;
    sample_t     smp;
    logic        typed;
    sample_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sample_t     sample_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sample_t     sample_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shifter state as the block should hold it
  sample_t           delay_mem [RING_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [POS_W-1:0]  rd_pos;
  ratio_t            ratio_q;

  sample_t    pending_out [$];
  idle_mode_e idle_mode = IDLE_NONE;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int ratio_settings = 0;
  int backpressure_cycles = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;

  // first rows run from reset at ratio 1.0: the first sample reads back itself,
  // the rest read still-empty entries half a ring behind the write pointer
  dir_row_t dir_rows [23] = '{
    '{1'b0, 32'h0000_0000, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{1'b0, 32'h0000_0000, 24'h800000, 1'b1, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h000000, 1'b1, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'hFFFFFF, 1'b1, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h000001, 1'b1, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h555555, 1'b1, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'hAAAAAA, 1'b1, 24'h000000},
    '{1'b1, 32'h0000_8000, 24'h123456, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'hFEDCBA, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b1, 32'h0002_0000, 24'h800000, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h800000, 1'b0, 24'h000000},
    '{1'b1, 32'h0000_0000, 24'h0F0F0F, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'hF0F0F0, 1'b0, 24'h000000},
    '{1'b1, 32'hFFFF_FFFF, 24'h3C3C3C, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'hC3C3C3, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h000002, 1'b0, 24'h000000},
    '{1'b1, 32'h0001_4000, 24'h400000, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'hC00000, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b1, 32'h0001_0000, 24'h800000, 1'b0, 24'h000000},
    '{1'b0, 32'h0000_0000, 24'h000000, 1'b0, 24'h000000}
  };

  delay_line_pitch_shifter_core #(
    .DEPTH(RING_DEPTH),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic int tx_idle_pct(idle_mode_e m);
    case (m)
      IDLE_TX:   return 64;
      IDLE_BOTH: return 27;
      default:   return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct(idle_mode_e m);
    case (m)
      IDLE_RX:   return 64;
      IDLE_BOTH: return 27;
      default:   return 0;
    endcase
  endfunction

  function automatic void reset_shifter_state();
    foreach (delay_mem[i]) delay_mem[i] = '0;
    wr_ptr  = '0;
    rd_pos  = '0;
    ratio_q = RATIO_RESET;
  endfunction

  // write, interpolate at the old position, then advance and re-sync
  function automatic sample_t shift_sample(sample_t smp);
    logic [PTR_W-1:0]     tap0;
    logic [PTR_W-1:0]     tap1;
    logic [FRAC_BITS-1:0] frac;
    logic [POS_W-1:0]     lag;
    longint               s0;
    longint               s1;
    longint               prod;
    sample_t              y;
    delay_mem[wr_ptr] = smp;
    wr_ptr = wr_ptr + 1'b1;
    tap0 = rd_pos[POS_W-1:FRAC_BITS];
    tap1 = tap0 + 1'b1;
    frac = rd_pos[FRAC_BITS-1:0];
    s0 = delay_mem[tap0];
    s1 = delay_mem[tap1];
    prod = longint'(frac) * (s1 - s0);
    y = sample_t'(s0 + (prod >>> FRAC_BITS));
    rd_pos = rd_pos + POS_W'(ratio_q);
    lag = {wr_ptr, {FRAC_BITS{1'b0}}} - rd_pos;
    if (lag > HALF_SPAN) begin
      rd_pos = {wr_ptr - PTR_W'(RING_DEPTH / 4), {FRAC_BITS{1'b0}}};
    end else if (lag < QUARTER_SPAN) begin
      rd_pos = {wr_ptr - PTR_W'(RING_DEPTH / 2), {FRAC_BITS{1'b0}}};
    end
    return y;
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 24'h7FFFFF;
    if (r < 16) return 24'h800000;
    if (r < 28) return sample_t'(int'($urandom_range(0, 32)) - 16);
    return sample_t'($urandom());
  endfunction

  // setup, access, then idle so the next transfer starts on a fresh edge
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_ratio();
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RATIO_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {14'b0, ratio_q}) begin
      $display("%0t: pitch_ratio readback mismatch, expected %h, got %h",
               $time, {14'b0, ratio_q}, rd);
      errors++;
    end
    @(posedge clk);
  endtask

  task automatic set_ratio(logic [31:0] word);
    apb_write(RATIO_ADDR, word);
    ratio_q = word[RATIO_W-1:0];
    ratio_settings++;
    check_ratio();
  endtask

  // lower valid and wait until every predicted sample has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic push_sample(sample_t smp, logic typed, sample_t want);
    int      gap;
    sample_t y;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct(idle_mode)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    y = shift_sample(smp);
    pending_out.push_back(typed ? want : y);
    items_sent++;
  endtask

  // receiver: check returned samples, then pick ready for the next cycle
  always @(posedge clk) begin
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected sample_out, expected none, got %0d", $time, sample_out);
        errors++;
      end else begin
        want = pending_out.pop_front();
        results_checked++;
        if (sample_out !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want, sample_out);
          errors++;
        end
      end
    end
    if (idle_mode == IDLE_PRESSURE && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct(idle_mode));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && in_valid && !in_ready) backpressure_cycles++;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [31:0] word;
    idle_mode_e  mode;
    reset_shifter_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_ratio();

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_ratio) begin
        drain();
        set_ratio(dir_rows[i].ratio_word);
      end
      push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       begin word = 32'h0000_8000;                mode = IDLE_NONE;     end
        1:       begin word = 32'h0002_0000;                mode = IDLE_TX;       end
        2:       begin word = 32'h0000_0000;                mode = IDLE_RX;       end
        3:       begin word = 32'hFFFF_FFFF;                mode = IDLE_BOTH;     end
        4:       begin word = $urandom_range(32768, 131072); mode = IDLE_PRESSURE; end
        5:       begin word = $urandom();                   mode = IDLE_NONE;     end
        6:       begin word = $urandom_range(32768, 131072); mode = IDLE_TX;       end
        default: begin word = 32'h0001_0000;                mode = IDLE_BOTH;     end
      endcase
      // a write outside the register map must leave the ratio alone
      if (ph == 6) begin
        apb_write(UNUSED_ADDR, 32'hFFFF_FFFF);
        check_ratio();
      end
      set_ratio(word);
      idle_mode = mode;
      repeat (PHASE_ITEMS) push_sample(rand_sample(), 1'b0, '0);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d samples, %0d results checked, across %0d ratio settings",
             items_sent, results_checked, ratio_settings);
    $display("Input held off (mid-item or by a full output queue) for %0d cycles",
             backpressure_cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
